// ===== hw/rtl/kas_pkg.sv =====
// shared widths, codes and handshake structs for the keyframe animation stepper
`timescale 1ns / 1ps

package kas_pkg;

  localparam int CNT_W    = 11;                // frame count register
  localparam int TIME_W   = 40;                // Q16.16 time with headroom
  localparam int FRAME_W  = 10;                // frame index on the output
  localparam int DUR_W    = 24;
  localparam int STEP_W   = 16;
  localparam int PASS_W   = 16;
  localparam int FRAC_W   = 16;
  localparam int MODE_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_DATA_W = 64;
  localparam int PROD_W   = TIME_W + CNT_W;

  // iteration counts of the serial units
  localparam int MUL_ITERS  = CNT_W;
  localparam int WRAP_ITERS = TIME_W;
  localparam int POS_ITERS  = CNT_W + FRAC_W;
  localparam int ITER_W     = $clog2(WRAP_ITERS + 1);
  localparam int MUL_CNT_W  = $clog2(MUL_ITERS + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK   = 3'd0,
    MODE_START  = 3'd1,
    MODE_PAUSE  = 3'd2,
    MODE_RESUME = 3'd3,
    MODE_STOP   = 3'd4
  } kas_mode_e;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP       = 2'd3;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] a;
    logic [CNT_W-1:0]  b;
  } kas_mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] p;
  } kas_mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] rem_init;
    logic [TIME_W-1:0] bits;
    logic [TIME_W-1:0] divisor;
    logic [ITER_W-1:0] iters;
  } kas_div_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quo;
    logic [TIME_W-1:0] rem;
  } kas_div_rsp_t;

endpackage

// ===== hw/rtl/kas_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module kas_mul import kas_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  kas_mul_req_t req_i,
  output kas_mul_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [PROD_W-1:0]    a_q;
  logic [CNT_W-1:0]     b_q;
  logic [PROD_W-1:0]    acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= MUL_CNT_W'(MUL_ITERS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == MUL_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= PROD_W'(req_i.a);
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.p    = acc_q;

endmodule

// ===== hw/rtl/kas_div.sv =====
// restoring divider, one quotient bit per cycle, dividend bits shifted in msb first
`timescale 1ns / 1ps

module kas_div import kas_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  kas_div_req_t req_i,
  output kas_div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [ITER_W-1:0] cnt_q;
  logic [TIME_W-1:0] rem_q;
  logic [TIME_W-1:0] bits_q;
  logic [TIME_W-1:0] quo_q;
  logic [TIME_W-1:0] den_q;

  logic [TIME_W:0]   trial;
  logic [TIME_W-1:0] diff;
  logic              ge;

  // remainder stays below the divisor, so the trial fits one extra bit
  // and a taken subtraction always lands below the divisor again
  assign trial = {rem_q, bits_q[TIME_W-1]};
  assign diff  = trial[TIME_W-1:0] - den_q;
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.rem_init;
      bits_q <= req_i.bits;
      den_q  <= req_i.divisor;
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff : trial[TIME_W-1:0];
      bits_q <= bits_q << 1;
      quo_q  <= {quo_q[TIME_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hw/rtl/keyframe_animation_stepper.sv =====
// keyframe animation stepper top level: command fsm, state and serial arithmetic
//
//   channel  | direction | handshake                    | payload
//   s_axis   | in        | s_axis_tvalid / s_axis_tready | tuser: mode, tdata: delta_time
//   m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: frame and status word
//   cfg      | in        | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// pause, resume, stop, ignored or clamping ticks, refused starts: no serial arithmetic before the result word.
// start: the 11 steps of the bit-serial multiplier form the end time.
// tick within the run: 11 multiply steps, then 27 divide steps.
// tick that wraps a looping run: 40 divide steps for the wrap come before those.
// s_axis_tready is high only while no word is in work; a finished word waits in the
// output register and the next word is taken meanwhile. reset is asynchronous, active low.
`timescale 1ns / 1ps

module keyframe_animation_stepper import kas_pkg::*; #(
  parameter int MAX_FRAMES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DUR_W-1:0]      s_axis_tdata,   // [23:0] delta_time
  input  logic [MODE_W-1:0]     s_axis_tuser,   // [2:0] mode
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [9:0] frame_index, [19:10] next_frame, [35:20] blend_weight, [36] active,
  // [37] paused, [38] finished, [54:39] cycle_count, [55] frame_changed,
  // [56] accepted, [63:57] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CountCap = (MAX_FRAMES > 2047) ? 2047 : MAX_FRAMES;
  localparam logic [CNT_W-1:0] CountCapW = CNT_W'(CountCap);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_END,
    ST_DIV_WRAP,
    ST_MUL_GO,
    ST_MUL_POS,
    ST_DIV_POS,
    ST_FIN
  } state_e;

  // configuration
  logic [CNT_W-1:0]  frame_count_q;
  logic [DUR_W-1:0]  frame_duration_q;
  logic              loop_enable_q;
  logic [STEP_W-1:0] min_step_q;

  // animation state
  state_e            state_q;
  logic [TIME_W-1:0] elapsed_q;
  logic [TIME_W-1:0] end_q;
  logic [CNT_W-1:0]  base_q;
  logic [CNT_W-1:0]  follow_q;
  logic [FRAC_W-1:0] mix_q;
  logic [PASS_W-1:0] passes_q;
  logic              running_q;
  logic              looping_q;
  logic              halted_q;
  logic [CNT_W-1:0]  prev_base_q;
  logic              acc_q;
  logic              out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  kas_mul_req_t mul_req;
  kas_mul_rsp_t mul_rsp;
  kas_div_req_t div_req;
  kas_div_rsp_t div_rsp;

  kas_mode_e         mode;
  logic              in_fire;
  logic [CNT_W-1:0]  count_eff;
  logic [CNT_W-1:0]  tick_count;
  logic [CNT_W-1:0]  final_cnt;
  logic [DUR_W-1:0]  dur_eff;
  logic [TIME_W-1:0] sum_t;
  logic              tick_live;
  logic              start_ok;
  logic              tick_wrap;
  logic [PASS_W:0]   pass_sum;
  logic [PASS_W-1:0] pass_wrap;
  logic [PASS_W-1:0] pass_inc;
  logic [CNT_W-1:0]  q_base;
  logic [CNT_W:0]    q_next;
  logic              out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q    <= CNT_W'(1);
      frame_duration_q <= DUR_W'(65536);
      loop_enable_q    <= 1'b0;
      min_step_q       <= STEP_W'(7);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_COUNT:    frame_count_q    <= cfg_data_i[CNT_W-1:0];
        REG_FRAME_DURATION: frame_duration_q <= cfg_data_i[DUR_W-1:0];
        REG_LOOP_ENABLE:    loop_enable_q    <= cfg_data_i[0];
        REG_MIN_STEP:       min_step_q       <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign mode          = kas_mode_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign count_eff  = (frame_count_q > CountCapW) ? CountCapW : frame_count_q;
  assign tick_count = (count_eff == '0) ? CNT_W'(1) : count_eff;
  assign final_cnt  = tick_count - 1'b1;
  assign dur_eff    = (frame_duration_q == '0) ? DUR_W'(1) : frame_duration_q;
  assign start_ok   = count_eff > CNT_W'(1);

  // elapsed stays at or below the end time, so the sum never wraps
  assign sum_t     = elapsed_q + TIME_W'(s_axis_tdata);
  assign tick_live = running_q && !halted_q && (s_axis_tdata >= DUR_W'(min_step_q));
  assign tick_wrap = (mode == MODE_TICK) && tick_live && (end_q != '0)
                     && (sum_t > end_q) && looping_q;

  // saturating pass counters
  assign pass_sum  = {1'b0, passes_q} + {1'b0, div_rsp.quo[PASS_W-1:0]};
  assign pass_wrap = ((|div_rsp.quo[TIME_W-1:PASS_W]) || pass_sum[PASS_W]) ?
                     '1 : pass_sum[PASS_W-1:0];
  assign pass_inc  = (&passes_q) ? passes_q : passes_q + 1'b1;

  assign q_base = div_rsp.quo[POS_ITERS-1:FRAC_W];
  assign q_next = {1'b0, q_base} + (CNT_W + 1)'(1);

  // multiplier: end time at start, frame position on a tick
  always_comb begin
    mul_req.start = (in_fire && (mode == MODE_START) && start_ok) || (state_q == ST_MUL_GO);
    if (state_q == ST_IDLE) begin
      mul_req.a = TIME_W'(dur_eff);
      mul_req.b = count_eff;
    end else begin
      mul_req.a = elapsed_q;
      mul_req.b = final_cnt;
    end
  end

  // divider: wrap of a looping run, then position into frame and weight
  always_comb begin
    div_req.start   = (in_fire && tick_wrap) || ((state_q == ST_MUL_POS) && mul_rsp.done);
    div_req.divisor = end_q;
    if (state_q == ST_IDLE) begin
      div_req.rem_init = '0;
      div_req.bits     = sum_t;
      div_req.iters    = ITER_W'(WRAP_ITERS);
    end else begin
      // quotient is below 2^11, so the upper product bits start as remainder
      div_req.rem_init = mul_rsp.p[PROD_W-1:CNT_W];
      div_req.bits     = {mul_rsp.p[CNT_W-1:0], {(TIME_W - CNT_W){1'b0}}};
      div_req.iters    = ITER_W'(POS_ITERS);
    end
  end

  kas_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  kas_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      elapsed_q   <= '0;
      end_q       <= '0;
      base_q      <= '0;
      follow_q    <= CNT_W'(1);
      mix_q       <= '0;
      passes_q    <= '0;
      running_q   <= 1'b0;
      looping_q   <= 1'b0;
      halted_q    <= 1'b0;
      prev_base_q <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            prev_base_q <= base_q;
            acc_q       <= 1'b0;
            state_q     <= ST_FIN;
            case (mode)
              MODE_TICK: begin
                if (tick_live) begin
                  if (end_q == '0) begin
                    running_q <= 1'b0;
                  end else if (sum_t > end_q) begin
                    if (looping_q) begin
                      state_q <= ST_DIV_WRAP;
                    end else begin
                      // run past the end: clamp to the final frame and stop
                      elapsed_q <= end_q;
                      passes_q  <= pass_inc;
                      base_q    <= final_cnt;
                      follow_q  <= final_cnt;
                      mix_q     <= '0;
                      running_q <= 1'b0;
                    end
                  end else begin
                    elapsed_q <= sum_t;
                    state_q   <= ST_MUL_GO;
                  end
                end
              end
              MODE_START: begin
                if (start_ok) begin
                  base_q    <= '0;
                  follow_q  <= CNT_W'(1);
                  mix_q     <= '0;
                  passes_q  <= '0;
                  elapsed_q <= '0;
                  end_q     <= '0;
                  running_q <= 1'b0;
                  halted_q  <= 1'b0;
                  looping_q <= loop_enable_q;
                  state_q   <= ST_MUL_END;
                end
              end
              MODE_PAUSE: begin
                if (running_q) begin
                  halted_q <= 1'b1;
                end
              end
              MODE_RESUME: begin
                if (running_q) begin
                  halted_q <= 1'b0;
                end
              end
              MODE_STOP: begin
                base_q    <= '0;
                follow_q  <= CNT_W'(1);
                mix_q     <= '0;
                passes_q  <= '0;
                elapsed_q <= '0;
                end_q     <= '0;
                running_q <= 1'b0;
                looping_q <= 1'b0;
                halted_q  <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_MUL_END: begin
          if (mul_rsp.done) begin
            end_q     <= mul_rsp.p[TIME_W-1:0];
            running_q <= 1'b1;
            acc_q     <= 1'b1;
            state_q   <= ST_FIN;
          end
        end
        ST_DIV_WRAP: begin
          if (div_rsp.done) begin
            passes_q  <= pass_wrap;
            elapsed_q <= div_rsp.rem;
            state_q   <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: begin
          state_q <= ST_MUL_POS;
        end
        ST_MUL_POS: begin
          if (mul_rsp.done) begin
            state_q <= ST_DIV_POS;
          end
        end
        ST_DIV_POS: begin
          if (div_rsp.done) begin
            base_q   <= q_base;
            mix_q    <= div_rsp.quo[FRAC_W-1:0];
            follow_q <= (q_next == {1'b0, tick_count}) ? '0 : q_next[CNT_W-1:0];
            state_q  <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {7'b0, acc_q, (prev_base_q != base_q), passes_q,
                            (!running_q && (passes_q != '0)), halted_q, running_q,
                            mix_q, follow_q[FRAME_W-1:0], base_q[FRAME_W-1:0]};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/kas_checker.sv =====
// port-level checks on the result stream of the keyframe animation stepper
`timescale 1ns / 1ps

module kas_checker import kas_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [FRAME_W-1:0] frame_index;
  logic [FRAC_W-1:0]  blend_weight;
  logic               active;
  logic               paused;
  logic [PASS_W-1:0]  cycle_count;
  logic               accepted;

  assign frame_index  = m_axis_tdata[9:0];
  assign blend_weight = m_axis_tdata[35:20];
  assign active       = m_axis_tdata[36];
  assign paused       = m_axis_tdata[37];
  assign cycle_count  = m_axis_tdata[54:39];
  assign accepted     = m_axis_tdata[56];

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && paused |-> active)
    else $error("paused without an active run");

  // a taken start leaves a fresh run at frame zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && accepted |->
      active && !paused && (frame_index == '0) && (blend_weight == '0) && (cycle_count == '0))
    else $error("accepted start without a cleared running state");

  // an idle animation is always parked on a whole frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !active |-> (blend_weight == '0))
    else $error("blend weight nonzero while inactive");

endmodule

bind keyframe_animation_stepper kas_checker u_kas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
